/* hw/rtl/multilevel_feedback_queue_scheduler_assert.svh */
// assertion macros for the feedback queue scheduler
// implication and next-cycle forms, no other dependencies
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
`define MLFQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mlfq assertion failed");
`define MLFQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mlfq assertion failed");
`else
`define MLFQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define MLFQ_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/mlfq_pkg.sv */
// shared constants and types of the feedback queue scheduler
// no dependencies
`timescale 1ns / 1ps
package mlfq_pkg;
  localparam int MAX_QUEUES_DEF    = 8;
  localparam int MAX_PROCESSES_DEF = 16;
  localparam int MAX_OPS_DEF       = 64;

  localparam logic [1:0] MODE_LOAD     = 2'd0;
  localparam logic [1:0] MODE_START    = 2'd1;
  localparam logic [1:0] MODE_DISPATCH = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  localparam logic [1:0] OP_STAY    = 2'd0;
  localparam logic [1:0] OP_DEMOTE  = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;
  localparam logic [1:0] OP_END_ALT = 2'd3;

  localparam logic [2:0] EV_ACK      = 3'd0;
  localparam logic [2:0] EV_RAN      = 3'd1;
  localparam logic [2:0] EV_FINISHED = 3'd2;
  localparam logic [2:0] EV_BOOSTED  = 3'd3;
  localparam logic [2:0] EV_ALL_DONE = 3'd4;

  localparam logic [1:0] CFG_NUM_QUEUES    = 2'd0;
  localparam logic [1:0] CFG_NUM_PROCESSES = 2'd1;
  localparam logic [1:0] CFG_BOOST_PERIOD  = 2'd2;

  typedef struct packed {
    logic [2:0] ev;
    logic       op;
    logic [3:0] pid;
    logic [3:0] lvl;
  } result_t;
endpackage

/* hw/rtl/mlfq_op_store.sv */
// operation list store, one entry per process and position
// positions past the list read as end marker; uses mlfq_pkg
`timescale 1ns / 1ps
module mlfq_op_store #(
  parameter int MAX_PROCESSES = mlfq_pkg::MAX_PROCESSES_DEF,
  parameter int MAX_OPS       = mlfq_pkg::MAX_OPS_DEF,
  localparam int PW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
  localparam int XW = $clog2(MAX_OPS + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [3:0]    wr_proc,
  input  logic [5:0]    wr_idx,
  input  logic [1:0]    wr_op,
  input  logic          rd_en,
  input  logic [PW-1:0] rd_proc,
  input  logic [XW-1:0] rd_idx,
  output logic [1:0]    rd_op
);
  localparam int DEPTH = MAX_PROCESSES * MAX_OPS;
  localparam int SW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [1:0]    mem [DEPTH];
  logic [1:0]    rd_data;
  logic          rd_hit;
  logic          wr_ok;
  logic          rd_ok;
  logic [SW-1:0] wa;
  logic [SW-1:0] ra;

  assign wr_ok = (32'(wr_proc) < 32'(MAX_PROCESSES)) && (32'(wr_idx) < 32'(MAX_OPS));
  assign rd_ok = 32'(rd_idx) < 32'(MAX_OPS);
  assign wa = SW'(32'(wr_proc) * 32'(MAX_OPS) + 32'(wr_idx));
  assign ra = SW'(32'(rd_proc) * 32'(MAX_OPS) + 32'(rd_idx));

  always_ff @(posedge clk) begin
    if (we && wr_ok) begin
      mem[wa] <= wr_op;
    end
    if (rd_en) begin
      rd_data <= mem[ra];
      rd_hit  <= rd_ok;
    end
  end

  assign rd_op = rd_hit ? rd_data : mlfq_pkg::OP_END;
endmodule

/* hw/rtl/multilevel_feedback_queue_scheduler.sv */
// multilevel feedback queue scheduler with periodic priority boost
// load/unused mode returns one result; start admits each configured process into queue 0
// dispatch scans the queues from level 0 up; a boost moves every process of levels 1 and up to queue 0
// a result held by out_stall holds the scheduler; one transaction in flight at a time
// reset clears control, queues, pointers and counters; op store and slots stay unset
`timescale 1ns / 1ps
`include "multilevel_feedback_queue_scheduler_assert.svh"
module multilevel_feedback_queue_scheduler #(
  parameter int MAX_QUEUES    = mlfq_pkg::MAX_QUEUES_DEF,
  parameter int MAX_PROCESSES = mlfq_pkg::MAX_PROCESSES_DEF,
  parameter int MAX_OPS       = mlfq_pkg::MAX_OPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [3:0]  process_index,
  input  logic [5:0]  op_index,
  input  logic [1:0]  op_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic        op_run,
  output logic [3:0]  process_id,
  output logic [3:0]  level_label,
  output logic        last
);
  localparam int QW  = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int QCW = $clog2(MAX_QUEUES + 1);
  localparam int PW  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CW  = $clog2(MAX_PROCESSES + 1);
  localparam int XW  = $clog2(MAX_OPS + 1);
  localparam int SLOTS = MAX_QUEUES * MAX_PROCESSES;
  localparam int SAW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_PWT   = 4'd3;
  localparam logic [3:0] S_OP0   = 4'd4;
  localparam logic [3:0] S_OP1   = 4'd5;
  localparam logic [3:0] S_BSCAN = 4'd6;
  localparam logic [3:0] S_BWT   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_LAST  = 4'd9;

  logic [3:0]  num_queues;
  logic [4:0]  num_processes;
  logic [15:0] boost_period;

  logic [3:0]     state;
  logic [QW-1:0]  scan_level;
  logic [QCW-1:0] y;
  logic [CW-1:0]  k;
  logic [PW-1:0]  p;
  logic [XW-1:0]  x;
  logic [1:0]     op0;
  logic [15:0]    step_counter;
  logic [PW-1:0]  queue_head [MAX_QUEUES];
  logic [CW-1:0]  queue_count [MAX_QUEUES];
  logic [XW-1:0]  op_pointer [MAX_PROCESSES];
  logic [PW-1:0]  queue_slots [SLOTS];
  logic [PW-1:0]  slot_rd;
  mlfq_pkg::result_t pend;
  logic              pv;

  logic [QCW-1:0] nq;
  logic [CW-1:0]  cnt;
  logic [QW-1:0]  target;
  logic [QW-1:0]  qsel;
  logic [PW-1:0]  cur_head;
  logic [CW-1:0]  cur_count;
  logic [PW-1:0]  head_inc;
  logic [CW:0]    tail_sum;
  logic [PW-1:0]  tail;
  logic           all_empty;
  logic           out_free;
  logic           out_load;
  logic           need_emit;
  logic           adv;
  logic           fin;
  logic [15:0]    step_inc;
  logic [7:0]     lvl_full;
  mlfq_pkg::result_t new_res;
  logic           slot_re;
  logic           slot_we;
  logic [PW-1:0]  slot_wd;
  logic [SAW-1:0] slot_ra;
  logic [SAW-1:0] slot_wa;
  logic           st_we;
  logic           st_re;
  logic [PW-1:0]  st_proc;
  logic [XW-1:0]  st_idx;
  logic [1:0]     st_op;

  assign nq = (num_queues == 4'd0) ? QCW'(1) :
              (32'(num_queues) > 32'(MAX_QUEUES)) ? QCW'(MAX_QUEUES) : QCW'(num_queues);
  assign cnt = (32'(num_processes) > 32'(MAX_PROCESSES)) ? CW'(MAX_PROCESSES)
                                                         : CW'(num_processes);

  assign target = ((op0 == mlfq_pkg::OP_DEMOTE) &&
                   ((QCW+1)'(scan_level) + (QCW+1)'(1) < (QCW+1)'(nq)))
                  ? QW'(scan_level + QW'(1)) : scan_level;

  always_comb begin
    unique case (state)
      S_BSCAN:        qsel = QW'(y);
      S_BWT, S_START: qsel = '0;
      S_OP1:          qsel = target;
      default:        qsel = scan_level;
    endcase
  end

  assign cur_head  = queue_head[qsel];
  assign cur_count = queue_count[qsel];
  assign head_inc  = (32'(cur_head) == 32'(MAX_PROCESSES - 1)) ? '0 : PW'(cur_head + PW'(1));
  assign tail_sum  = (CW+1)'(cur_head) + (CW+1)'(cur_count);
  assign tail      = (32'(tail_sum) >= 32'(MAX_PROCESSES))
                     ? PW'(tail_sum - (CW+1)'(MAX_PROCESSES)) : PW'(tail_sum);

  always_comb begin
    all_empty = 1'b1;
    for (int i = 0; i < MAX_QUEUES; i++) begin
      if (queue_count[i] != '0) begin
        all_empty = 1'b0;
      end
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign fin      = op0[1] || st_op[1];
  assign step_inc = step_counter + 16'd1;
  assign lvl_full = 8'(nq) - 8'(target);

  always_comb begin
    need_emit = 1'b0;
    new_res   = '{ev: mlfq_pkg::EV_ACK, op: 1'b0, pid: 4'd0, lvl: 4'd0};
    unique case (state)
      S_IDLE: begin
        if (in_valid && (mode != mlfq_pkg::MODE_START) && (mode != mlfq_pkg::MODE_DISPATCH)) begin
          need_emit = 1'b1;
        end
      end
      S_START: begin
        need_emit = (k >= cnt);
      end
      S_SCAN: begin
        if (cur_count == '0 && 32'(scan_level) == 32'(MAX_QUEUES - 1)) begin
          need_emit  = 1'b1;
          new_res.ev = mlfq_pkg::EV_ALL_DONE;
        end
      end
      S_OP1: begin
        need_emit = 1'b1;
        if (fin) begin
          new_res = '{ev: mlfq_pkg::EV_FINISHED, op: 1'b0, pid: 4'(p), lvl: 4'd0};
        end else begin
          new_res = '{ev: mlfq_pkg::EV_RAN, op: op0[0], pid: 4'(p), lvl: lvl_full[3:0]};
        end
      end
      S_BWT: begin
        need_emit = 1'b1;
        new_res   = '{ev: mlfq_pkg::EV_BOOSTED, op: 1'b0, pid: 4'(slot_rd), lvl: 4'(nq)};
      end
      S_FIN: begin
        if (all_empty) begin
          need_emit  = 1'b1;
          new_res.ev = mlfq_pkg::EV_ALL_DONE;
        end
      end
      default: begin
        need_emit = 1'b0;
      end
    endcase
  end

  assign adv = !(need_emit && pv && !out_free);
  assign out_load = (need_emit && adv && pv) || (state == S_LAST && out_free);

  always_comb begin
    slot_re = 1'b0;
    slot_we = 1'b0;
    slot_wd = slot_rd;
    unique case (state)
      S_START: begin
        slot_we = (k < cnt);
        slot_wd = PW'(k);
      end
      S_SCAN, S_BSCAN: begin
        slot_re = (cur_count != '0) && !(state == S_BSCAN && y == QCW'(MAX_QUEUES));
      end
      S_OP1: begin
        slot_we = adv && !fin;
        slot_wd = p;
      end
      S_BWT: begin
        slot_we = adv;
      end
      default: begin
        slot_re = 1'b0;
      end
    endcase
  end

  assign slot_ra = SAW'(32'(qsel) * 32'(MAX_PROCESSES) + 32'(cur_head));
  assign slot_wa = SAW'(32'(qsel) * 32'(MAX_PROCESSES) + 32'(tail));

  always_ff @(posedge clk) begin
    if (slot_we) begin
      queue_slots[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_rd <= queue_slots[slot_ra];
    end
  end

  assign st_we   = (state == S_IDLE) && in_valid && (mode == mlfq_pkg::MODE_LOAD);
  assign st_re   = (state == S_PWT) || (state == S_OP0);
  assign st_proc = (state == S_PWT) ? slot_rd : p;
  assign st_idx  = (state == S_PWT) ? op_pointer[slot_rd] : XW'(x + XW'(1));

  mlfq_op_store #(
    .MAX_PROCESSES(MAX_PROCESSES),
    .MAX_OPS(MAX_OPS)
  ) u_store (
    .clk(clk),
    .we(st_we),
    .wr_proc(process_index),
    .wr_idx(op_index),
    .wr_op(op_code),
    .rd_en(st_re),
    .rd_proc(st_proc),
    .rd_idx(st_idx),
    .rd_op(st_op)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_queues    <= 4'd3;
      num_processes <= 5'd1;
      boost_period  <= 16'd10;
      state         <= S_IDLE;
      scan_level    <= '0;
      y             <= '0;
      k             <= '0;
      step_counter  <= '0;
      pv            <= 1'b0;
      out_valid     <= 1'b0;
      for (int i = 0; i < MAX_QUEUES; i++) begin
        queue_head[i]  <= '0;
        queue_count[i] <= '0;
      end
      for (int i = 0; i < MAX_PROCESSES; i++) begin
        op_pointer[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mlfq_pkg::CFG_NUM_QUEUES:    num_queues    <= cfg_data[3:0];
          mlfq_pkg::CFG_NUM_PROCESSES: num_processes <= cfg_data[4:0];
          mlfq_pkg::CFG_BOOST_PERIOD:  boost_period  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (out_valid && !out_stall && !out_load) begin
        out_valid <= 1'b0;
      end
      if (need_emit && adv) begin
        if (pv) begin
          event_res   <= pend.ev;
          op_run      <= pend.op;
          process_id  <= pend.pid;
          level_label <= pend.lvl;
          last        <= 1'b0;
          out_valid   <= 1'b1;
        end
        pend <= new_res;
        pv   <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (mode)
              mlfq_pkg::MODE_START: begin
                for (int i = 0; i < MAX_QUEUES; i++) begin
                  queue_head[i]  <= '0;
                  queue_count[i] <= '0;
                end
                for (int i = 0; i < MAX_PROCESSES; i++) begin
                  op_pointer[i] <= '0;
                end
                step_counter <= '0;
                scan_level   <= '0;
                k            <= '0;
                state        <= S_START;
              end
              mlfq_pkg::MODE_DISPATCH: begin
                scan_level <= '0;
                state      <= S_SCAN;
              end
              default: begin
                state <= S_LAST;
              end
            endcase
          end
        end
        S_START: begin
          if (k < cnt) begin
            queue_count[qsel] <= CW'(cur_count + CW'(1));
            k <= CW'(k + CW'(1));
          end else begin
            state <= S_LAST;
          end
        end
        S_SCAN: begin
          if (cur_count != '0) begin
            queue_head[qsel]  <= head_inc;
            queue_count[qsel] <= CW'(cur_count - CW'(1));
            state <= S_PWT;
          end else if (32'(scan_level) == 32'(MAX_QUEUES - 1)) begin
            state <= S_LAST;
          end else begin
            scan_level <= QW'(scan_level + QW'(1));
          end
        end
        S_PWT: begin
          p     <= slot_rd;
          x     <= op_pointer[slot_rd];
          state <= S_OP0;
        end
        S_OP0: begin
          op0   <= st_op;
          state <= S_OP1;
        end
        S_OP1: begin
          if (adv) begin
            if (!op0[1]) begin
              op_pointer[p] <= XW'(x + XW'(1));
            end
            if (!fin) begin
              queue_count[qsel] <= CW'(cur_count + CW'(1));
            end
            if (step_inc == boost_period) begin
              step_counter <= '0;
              scan_level   <= '0;
              y            <= QCW'(1);
              state        <= S_BSCAN;
            end else begin
              step_counter <= step_inc;
              state        <= S_FIN;
            end
          end
        end
        S_BSCAN: begin
          if (y == QCW'(MAX_QUEUES)) begin
            state <= S_FIN;
          end else if (cur_count != '0) begin
            queue_head[qsel]  <= head_inc;
            queue_count[qsel] <= CW'(cur_count - CW'(1));
            state <= S_BWT;
          end else begin
            y <= QCW'(y + QCW'(1));
          end
        end
        S_BWT: begin
          if (adv) begin
            queue_count[qsel] <= CW'(cur_count + CW'(1));
            state <= S_BSCAN;
          end
        end
        S_FIN: begin
          if (adv) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (out_free) begin
            event_res   <= pend.ev;
            op_run      <= pend.op;
            process_id  <= pend.pid;
            level_label <= pend.lvl;
            last        <= 1'b1;
            out_valid   <= 1'b1;
            pv          <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `MLFQ_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && !in_stall, state != S_IDLE)
  `MLFQ_ASSERT_IMP(a_idle_no_pend, clk, rst, state == S_IDLE, !pv)
  `MLFQ_ASSERT_IMP(a_scan_no_pend, clk, rst, state == S_SCAN, !pv)
endmodule
